// ===== design/lbps_pkg.sv =====
`timescale 1ns / 1ps

package lbps_pkg;

	// request codes
	localparam logic [1:0] ACT_TICK       = 2'd0;
	localparam logic [1:0] ACT_START      = 2'd1;
	localparam logic [1:0] ACT_FORCE_LOW  = 2'd2;
	localparam logic [1:0] ACT_FORCE_HIGH = 2'd3;

	// drive modes
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TONE  = 2'd1;
	localparam logic [1:0] MODE_PWM   = 2'd2;

	localparam int PATTERNS = 8;
	localparam int ROM_COLS = 16;
	localparam logic [2:0] OFF_PATTERN = 3'd1;
	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
	localparam logic [15:0] CYCLES_MAX = 16'hFFFF;

	// interval patterns in milliseconds, unused columns are zero
	localparam logic [15:0] PATTERN_ROM [PATTERNS][ROM_COLS] = '{
		'{16'd1000, 16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd500,  16'd500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd80,   16'd80,  16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd470,  16'd30,  16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd70,   16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd30,   16'd70,  16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd200,  16'd200, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
		  16'd0,    16'd0,   16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
	};

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] repeat_count;
		logic [2:0]  pattern_select;
		logic        set_tone;
		logic [15:0] tone_hz;
		logic        set_duty;
		logic [7:0]  duty_value;
	} cmd_t;

	typedef struct packed {
		logic        level;
		logic [1:0]  drive_mode;
		logic [15:0] drive_tone_hz;
		logic [7:0]  drive_duty;
		logic        write_strobe;
		logic [1:0]  phase_index;
	} led_t;

endpackage

// ===== design/lbps_core.sv =====
`timescale 1ns / 1ps

module lbps_core #(
	parameter int PHASES = 4,
	parameter int INTERVAL_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  lbps_pkg::cmd_t cmd,
	output lbps_pkg::led_t led
);

	localparam int PW = (PHASES > 1) ? $clog2(PHASES) : 1;
	localparam int CW = $clog2(PHASES + 1);
	localparam logic [32:0] IV_MAX = (33'd1 << INTERVAL_BITS) - 33'd1;

	logic          lit_q;
	logic [PW-1:0] phase_q;
	logic [2:0]    pattern_q;
	logic [15:0]   done_q;
	logic [15:0]   limit_q;
	logic [16:0]   elapsed_q;
	logic [15:0]   freq_q;
	logic [7:0]    duty_q;
	logic          wr_level_q;
	logic [15:0]   wr_freq_q;
	logic [7:0]    wr_duty_q;
	logic          wr_valid_q;

	logic          lit_d;
	logic [PW-1:0] phase_d;
	logic [2:0]    pattern_d;
	logic [15:0]   done_d;
	logic [15:0]   limit_d;
	logic [16:0]   elapsed_d;
	logic [15:0]   freq_d;
	logic [7:0]    duty_d;
	logic          record;
	logic          strobe;
	logic          plain;

	logic [16:0]              el_inc;
	logic [INTERVAL_BITS-1:0] iv_cur;
	logic [INTERVAL_BITS-1:0] iv_next;
	logic [INTERVAL_BITS-1:0] iv_first;
	logic [CW-1:0]            len_cur;
	logic [CW-1:0]            len_sel;
	logic [CW-1:0]            phase_inc;
	logic [15:0]              done_inc;
	logic                     same;

	// saturated interval, zero beyond the configured phase count
	function automatic logic [INTERVAL_BITS-1:0] interval_of(
		input logic [2:0] pat,
		input logic [CW-1:0] col
	);
		logic [32:0] raw;
		raw = 33'(lbps_pkg::PATTERN_ROM[pat][4'(col)]);
		if (32'(col) >= 32'(PHASES))
			raw = 33'd0;
		else if (raw > IV_MAX)
			raw = IV_MAX;
		return INTERVAL_BITS'(raw);
	endfunction

	// count of leading nonzero intervals
	function automatic logic [CW-1:0] length_of(input logic [2:0] pat);
		logic [CW-1:0] n;
		logic run;
		n = '0;
		run = 1'b1;
		for (int c = 0; c < PHASES; c++) begin
			if (run && lbps_pkg::PATTERN_ROM[pat][c] != 16'd0)
				n = n + CW'(1);
			else
				run = 1'b0;
		end
		return n;
	endfunction

	always_comb begin
		el_inc    = (elapsed_q < lbps_pkg::ELAPSED_MAX) ? elapsed_q + 17'd1 : elapsed_q;
		phase_inc = CW'(phase_q) + CW'(1);
		iv_cur    = interval_of(pattern_q, CW'(phase_q));
		iv_next   = interval_of(pattern_q, phase_inc);
		iv_first  = interval_of(pattern_q, CW'(0));
		len_cur   = length_of(pattern_q);
		len_sel   = length_of(cmd.pattern_select);
		done_inc  = (done_q < lbps_pkg::CYCLES_MAX) ? done_q + 16'd1 : done_q;
		same = (cmd.repeat_count == limit_q) &&
			(!cmd.set_tone || cmd.tone_hz == freq_q) &&
			(!cmd.set_duty || cmd.duty_value == duty_q) &&
			(cmd.pattern_select == pattern_q ||
			 (len_sel == '0 && len_cur == '0));

		lit_d     = lit_q;
		phase_d   = phase_q;
		pattern_d = pattern_q;
		done_d    = done_q;
		limit_d   = limit_q;
		elapsed_d = elapsed_q;
		freq_d    = freq_q;
		duty_d    = duty_q;
		record    = 1'b0;
		plain     = 1'b0;
		strobe    = 1'b0;

		case (cmd.action)
			lbps_pkg::ACT_TICK: begin
				record = 1'b1;
				if (33'(el_inc) <= 33'(iv_cur)) begin
					elapsed_d = el_inc;
				end else begin
					elapsed_d = '0;
					if (phase_inc < len_cur) begin
						phase_d = PW'(phase_inc);
						lit_d   = (iv_next != '0) && !phase_inc[0];
					end else if (limit_q != 16'd0 && done_inc >= limit_q) begin
						// last cycle done: fall back to the off pattern
						phase_d   = '0;
						lit_d     = 1'b0;
						done_d    = '0;
						limit_d   = '0;
						pattern_d = lbps_pkg::OFF_PATTERN;
					end else begin
						phase_d = '0;
						lit_d   = (iv_first != '0);
						if (limit_q != 16'd0)
							done_d = done_inc;
					end
				end
			end
			lbps_pkg::ACT_START: begin
				if (!same) begin
					record    = 1'b1;
					phase_d   = '0;
					done_d    = '0;
					limit_d   = cmd.repeat_count;
					pattern_d = cmd.pattern_select;
					elapsed_d = '0;
					lit_d     = (interval_of(cmd.pattern_select, CW'(0)) != '0);
					if (cmd.set_tone)
						freq_d = cmd.tone_hz;
					if (cmd.set_duty)
						duty_d = cmd.duty_value;
				end
			end
			lbps_pkg::ACT_FORCE_LOW: begin
				lit_d = 1'b0;
				plain = 1'b1;
			end
			lbps_pkg::ACT_FORCE_HIGH: begin
				lit_d = 1'b1;
				plain = 1'b1;
			end
			default: begin
				plain = 1'b0;
			end
		endcase

		if (plain)
			strobe = 1'b1;
		else if (record)
			strobe = !wr_valid_q || wr_level_q != lit_d ||
				wr_freq_q != freq_d || wr_duty_q != duty_d;

		led.level         = lit_d;
		led.drive_tone_hz = freq_d;
		led.drive_duty    = duty_d;
		led.write_strobe  = strobe;
		led.phase_index   = 2'(phase_d);
		if (plain)
			led.drive_mode = lbps_pkg::MODE_PLAIN;
		else if (freq_d != 16'd0)
			led.drive_mode = lbps_pkg::MODE_TONE;
		else if (duty_d != 8'd0)
			led.drive_mode = lbps_pkg::MODE_PWM;
		else
			led.drive_mode = lbps_pkg::MODE_PLAIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q      <= 1'b0;
			phase_q    <= '0;
			pattern_q  <= lbps_pkg::OFF_PATTERN;
			done_q     <= '0;
			limit_q    <= '0;
			elapsed_q  <= '0;
			freq_q     <= '0;
			duty_q     <= '0;
			wr_level_q <= 1'b0;
			wr_freq_q  <= '0;
			wr_duty_q  <= '0;
			wr_valid_q <= 1'b0;
		end else if (take) begin
			lit_q     <= lit_d;
			phase_q   <= phase_d;
			pattern_q <= pattern_d;
			done_q    <= done_d;
			limit_q   <= limit_d;
			elapsed_q <= elapsed_d;
			freq_q    <= freq_d;
			duty_q    <= duty_d;
			// forced writes leave the last-written record alone
			if (record) begin
				wr_level_q <= lit_d;
				wr_freq_q  <= freq_d;
				wr_duty_q  <= duty_d;
				wr_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ===== design/led_blink_pattern_sequencer_unit.sv =====
`timescale 1ns / 1ps

// LED blink pattern sequencer. Each request (millisecond tick, pattern start,
// force low, force high) yields exactly one result giving level, drive mode,
// tone, duty, a rewrite strobe and the current phase. Requests are taken one
// per cycle unless stalled: a request is registered, evaluated against the
// sequencer state in one combinational pass, and the result is registered in
// the output register once it is free. The output register lets a new request
// enter while the last result still waits; stall on the request side rises
// only when both input and output registers are full and the result is stalled.
// No clearing pass after reset; the pattern table is a constant ROM.

module led_blink_pattern_sequencer_unit #(
	parameter int PHASES = 4,
	parameter int INTERVAL_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  lbps_pkg::cmd_t cmd,
	output logic           led_valid,
	input  logic           led_stall,
	output lbps_pkg::led_t led
);

	logic           valid_s1;
	lbps_pkg::cmd_t cmd_s1;
	logic           led_valid_q;
	lbps_pkg::led_t led_q;
	lbps_pkg::led_t result;
	logic           advance;

	assign advance   = valid_s1 && (!led_valid_q || !led_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign led_valid = led_valid_q;
	assign led       = led_q;

	lbps_core #(
		.PHASES(PHASES),
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.take(advance),
		.cmd(cmd_s1),
		.led(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			led_valid_q <= 1'b0;
		end else begin
			if (!cmd_stall)
				valid_s1 <= cmd_valid;
			if (advance)
				led_valid_q <= 1'b1;
			else if (!led_stall)
				led_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall)
			cmd_s1 <= cmd;
		if (advance)
			led_q <= result;
	end

endmodule

// ===== verif/led_blink_pattern_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module led_blink_pattern_sequencer_unit_tb;

	localparam int PHASES = 4;
	localparam int INTERVAL_BITS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REQUESTS_PER_SETTING = 340;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	lbps_pkg::cmd_t cmd = '0;
	logic led_valid;
	logic led_stall = 1'b0;
	lbps_pkg::led_t led;

	lbps_pkg::cmd_t pending_cmds[$];
	lbps_pkg::led_t expected_leds[$];
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int unsigned failures = 0;
	int unsigned tb_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	// sequencer state as the predictor sees it
	logic        sq_lit = 1'b0;
	int unsigned sq_phase = 0;
	logic [2:0]  sq_pattern = lbps_pkg::OFF_PATTERN;
	logic [15:0] sq_cycles_done = '0;
	logic [15:0] sq_cycles_limit = '0;
	logic [16:0] sq_elapsed = '0;
	logic [15:0] sq_freq = '0;
	logic [7:0]  sq_duty = '0;
	logic        wr_level = 1'b0;
	logic [15:0] wr_freq = '0;
	logic [7:0]  wr_duty = '0;
	logic        wr_valid = 1'b0;

	led_blink_pattern_sequencer_unit #(
		.PHASES(PHASES),
		.INTERVAL_BITS(INTERVAL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.led_valid(led_valid),
		.led_stall(led_stall),
		.led(led)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint unsigned interval_ms(input logic [2:0] pat,
			input int unsigned col);
		longint unsigned lim;
		lim = (64'd1 << INTERVAL_BITS) - 1;
		if (col >= PHASES || col >= lbps_pkg::ROM_COLS)
			return 0;
		return (lbps_pkg::PATTERN_ROM[pat][col] > lim) ? lim :
			lbps_pkg::PATTERN_ROM[pat][col];
	endfunction

	function automatic int unsigned pattern_length(input logic [2:0] pat);
		int unsigned n;
		n = 0;
		while (n < PHASES && n < lbps_pkg::ROM_COLS && interval_ms(pat, n) > 0)
			n++;
		return n;
	endfunction

	function automatic void enter_phase(input int unsigned p);
		sq_phase = p;
		sq_lit = (interval_ms(sq_pattern, p) > 0 && p[0] == 1'b0);
		sq_elapsed = '0;
	endfunction

	function automatic void load_pattern(input logic [15:0] limit, input logic [2:0] sel,
			input logic st, input logic [15:0] tone, input logic sd, input logic [7:0] dv);
		sq_lit = 1'b0;
		sq_phase = 0;
		sq_cycles_done = '0;
		sq_cycles_limit = limit;
		sq_pattern = sel;
		if (st)
			sq_freq = tone;
		if (sd)
			sq_duty = dv;
		enter_phase(0);
	endfunction

	function automatic logic drive_changed();
		logic changed;
		changed = !wr_valid || wr_level != sq_lit || wr_freq != sq_freq || wr_duty != sq_duty;
		wr_level = sq_lit;
		wr_freq = sq_freq;
		wr_duty = sq_duty;
		wr_valid = 1'b1;
		return changed;
	endfunction

	function automatic void advance_ms();
		int unsigned cnt;
		if (sq_elapsed < lbps_pkg::ELAPSED_MAX)
			sq_elapsed++;
		if (sq_elapsed <= interval_ms(sq_pattern, sq_phase))
			return;
		cnt = pattern_length(sq_pattern);
		if (sq_phase + 1 < cnt) begin
			enter_phase(sq_phase + 1);
		end else if (sq_cycles_limit > 0) begin
			if (sq_cycles_done < lbps_pkg::CYCLES_MAX)
				sq_cycles_done++;
			if (sq_cycles_done < sq_cycles_limit)
				enter_phase(0);
			else
				load_pattern('0, lbps_pkg::OFF_PATTERN, 1'b0, '0, 1'b0, '0);
		end else begin
			enter_phase(0);
		end
	endfunction

	function automatic lbps_pkg::led_t predict_led(input lbps_pkg::cmd_t req);
		lbps_pkg::led_t r;
		logic plain;
		logic unchanged;
		r = '0;
		plain = 1'b0;
		r.write_strobe = 1'b0;
		case (req.action)
			lbps_pkg::ACT_TICK: begin
				advance_ms();
				r.write_strobe = drive_changed();
			end
			lbps_pkg::ACT_START: begin
				unchanged = req.repeat_count == sq_cycles_limit &&
					(!req.set_tone || req.tone_hz == sq_freq) &&
					(!req.set_duty || req.duty_value == sq_duty) &&
					(req.pattern_select == sq_pattern ||
					 (pattern_length(req.pattern_select) == 0 &&
					  pattern_length(sq_pattern) == 0));
				if (!unchanged) begin
					load_pattern(req.repeat_count, req.pattern_select, req.set_tone,
						req.tone_hz, req.set_duty, req.duty_value);
					r.write_strobe = drive_changed();
				end
			end
			default: begin
				// forced pin write leaves the last-written record alone
				sq_lit = (req.action == lbps_pkg::ACT_FORCE_HIGH);
				r.write_strobe = 1'b1;
				plain = 1'b1;
			end
		endcase
		if (plain)
			r.drive_mode = lbps_pkg::MODE_PLAIN;
		else if (sq_freq > 0)
			r.drive_mode = lbps_pkg::MODE_TONE;
		else if (sq_duty > 0)
			r.drive_mode = lbps_pkg::MODE_PWM;
		else
			r.drive_mode = lbps_pkg::MODE_PLAIN;
		r.level = sq_lit;
		r.drive_tone_hz = sq_freq;
		r.drive_duty = sq_duty;
		r.phase_index = sq_phase[1:0];
		return r;
	endfunction

	function automatic lbps_pkg::cmd_t scrambled_cmd(input logic [1:0] act);
		lbps_pkg::cmd_t req;
		req.action = act;
		req.repeat_count = 16'($urandom_range(65535));
		req.pattern_select = 3'($urandom_range(7));
		req.set_tone = 1'($urandom_range(1));
		req.tone_hz = 16'($urandom_range(65535));
		req.set_duty = 1'($urandom_range(1));
		req.duty_value = 8'($urandom_range(255));
		return req;
	endfunction

	task automatic push_cmd(input lbps_pkg::cmd_t req);
		pending_cmds.push_back(req);
		pushed_count++;
	endtask

	task automatic push_fields(input logic [1:0] act, input logic [15:0] rep,
			input logic [2:0] sel, input logic st, input logic [15:0] tone,
			input logic sd, input logic [7:0] dv);
		lbps_pkg::cmd_t req;
		req.action = act;
		req.repeat_count = rep;
		req.pattern_select = sel;
		req.set_tone = st;
		req.tone_hz = tone;
		req.set_duty = sd;
		req.duty_value = dv;
		push_cmd(req);
	endtask

	task automatic add_directed_requests();
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'hFFFF, 3'd7, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		push_fields(lbps_pkg::ACT_START, 16'd2, 3'd3, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		// identical start is skipped, and so is one that replaces nothing
		push_fields(lbps_pkg::ACT_START, 16'd2, 3'd3, 1'b1, 16'hFFFF, 1'b1, 8'hFF);
		push_fields(lbps_pkg::ACT_START, 16'd2, 3'd3, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_FORCE_HIGH, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_FORCE_LOW, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'hFFFF, 3'd5, 1'b1, 16'h0, 1'b1, 8'h80);
		// empty pattern expires on every tick
		push_fields(lbps_pkg::ACT_START, 16'd0, 3'd1, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'd1, 3'd1, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'd0, 3'd1, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'd3, 3'd6, 1'b1, 16'd1, 1'b1, 8'd1);
		push_fields(lbps_pkg::ACT_START, 16'd3, 3'd6, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'd0, 3'd0, 1'b1, 16'h0, 1'b1, 8'h0);
		push_fields(lbps_pkg::ACT_START, 16'h8000, 3'd7, 1'b1, 16'h5555, 1'b1, 8'hAA);
		push_fields(lbps_pkg::ACT_START, 16'h7FFF, 3'd4, 1'b1, 16'hAAAA, 1'b1, 8'h55);
		push_fields(lbps_pkg::ACT_START, 16'd1, 3'd2, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_FORCE_HIGH, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_FORCE_LOW, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
		push_fields(lbps_pkg::ACT_TICK, 16'h0, 3'd0, 1'b0, 16'h0, 1'b0, 8'h0);
	endtask

	task automatic add_random_requests(input int unsigned quota);
		int unsigned added;
		int unsigned run;
		int unsigned noise;
		lbps_pkg::cmd_t req;
		lbps_pkg::cmd_t last_start;
		logic [2:0] quick_pats [6];
		quick_pats = '{3'd3, 3'd5, 3'd6, 3'd1, 3'd3, 3'd6};
		added = 0;
		last_start = scrambled_cmd(lbps_pkg::ACT_START);
		while (added < quota) begin
			if ($urandom_range(99) < 80) begin
				// a start, then a run of ticks long enough to cross phases
				if ($urandom_range(9) == 0) begin
					req = last_start;
				end else begin
					req = scrambled_cmd(lbps_pkg::ACT_START);
					if ($urandom_range(4) != 0)
						req.pattern_select = quick_pats[$urandom_range(5)];
					if ($urandom_range(99) < 70)
						req.repeat_count = 16'($urandom_range(4));
					if ($urandom_range(3) == 0)
						req.tone_hz = '0;
					if ($urandom_range(3) == 0)
						req.duty_value = '0;
				end
				last_start = req;
				push_cmd(req);
				added++;
				run = $urandom_range(180, 10);
				for (int unsigned i = 0; i < run; i++) begin
					if ($urandom_range(99) < 3)
						req = scrambled_cmd($urandom_range(1) ?
							lbps_pkg::ACT_FORCE_HIGH : lbps_pkg::ACT_FORCE_LOW);
					else if ($urandom_range(99) < 2)
						req = last_start;
					else
						req = scrambled_cmd(lbps_pkg::ACT_TICK);
					push_cmd(req);
					added++;
				end
			end else begin
				noise = $urandom_range(4, 1);
				for (int unsigned i = 0; i < noise; i++) begin
					push_cmd(scrambled_cmd(2'($urandom_range(3))));
					added++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (accepted_count != pushed_count || expected_leds.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : drive_requests
		lbps_pkg::cmd_t nxt_cmd;
		logic nxt_valid;
		nxt_cmd = cmd;
		nxt_valid = cmd_valid;
		if (cmd_valid && !cmd_stall) begin
			expected_leds.push_back(predict_led(cmd));
			accepted_count++;
			nxt_valid = 1'b0;
		end
		if (!nxt_valid && arst_n && pending_cmds.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			nxt_cmd = pending_cmds.pop_front();
			nxt_valid = 1'b1;
		end
		cmd <= nxt_cmd;
		cmd_valid <= nxt_valid;
	end

	always @(posedge clk) begin : check_results
		lbps_pkg::led_t want;
		if (led_valid && !led_stall) begin
			if (expected_leds.size() == 0) begin
				$error("result with no request outstanding: %h", led);
				failures++;
			end else begin
				want = expected_leds.pop_front();
				if (led.level !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, led.level);
					failures++;
				end
				if (led.drive_mode !== want.drive_mode) begin
					$error("drive_mode: expected %0d, got %0d", want.drive_mode, led.drive_mode);
					failures++;
				end
				if (led.drive_tone_hz !== want.drive_tone_hz) begin
					$error("drive_tone_hz: expected %0d, got %0d",
						want.drive_tone_hz, led.drive_tone_hz);
					failures++;
				end
				if (led.drive_duty !== want.drive_duty) begin
					$error("drive_duty: expected %0d, got %0d", want.drive_duty, led.drive_duty);
					failures++;
				end
				if (led.write_strobe !== want.write_strobe) begin
					$error("write_strobe: expected %0d, got %0d",
						want.write_strobe, led.write_strobe);
					failures++;
				end
				if (led.phase_index !== want.phase_index) begin
					$error("phase_index: expected %0d, got %0d",
						want.phase_index, led.phase_index);
					failures++;
				end
			end
		end
		led_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		tb_cycles++;
		if (tb_cycles > CYCLE_LIMIT) begin
			$display("led_blink_pattern_sequencer_unit_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int s = 0; s < 3; s++) begin
			case (s)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 60;
				end
				1: begin
					send_idle_pct = 60;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (s == 0)
				add_directed_requests();
			add_random_requests(REQUESTS_PER_SETTING);
			// sender holds off until every result is back
			wait_drained();
		end
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("led_blink_pattern_sequencer_unit_tb OK");
		else
			$display("led_blink_pattern_sequencer_unit_tb NOT OK");
		$finish;
	end

endmodule
